// File: hdl/assert_macros.svh
// assertion macros shared by the rtl files
// they expect clk_i and rst_ni in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked at every clock edge outside reset
`define SWMC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("swmc: invariant violated");

// condition on one edge implies a condition on the next edge
`define SWMC_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("swmc: sequence check failed");

`else

`define SWMC_ASSERT(lbl, prop)
`define SWMC_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

// File: hdl/swmc_pkg.sv
package swmc_pkg;

  // payload widths
  localparam int unsigned CharW     = 8;
  localparam int unsigned MatchW    = 16;
  localparam int unsigned CountW    = 16;
  localparam int unsigned DigitW    = 3;
  localparam int unsigned NumDigits = 3;
  localparam int unsigned CodeW     = DigitW * NumDigits;
  localparam int unsigned DwW       = $clog2(NumDigits + 1);

  // queue between front and back
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  // word kinds
  localparam logic KindKey  = 1'b0;
  localparam logic KindText = 1'b1;

  // delimiters
  localparam logic [CharW-1:0] ChDot   = 8'h2E;
  localparam logic [CharW-1:0] ChComma = 8'h2C;
  localparam logic [CharW-1:0] ChSpace = 8'h20;

  // classified word as it travels through the queue
  typedef struct packed {
    logic              kind;
    logic [CharW-1:0]  ch;
    logic [DigitW-1:0] digit;
    logic              delim;
    logic              last;
  } swmc_entry_t;

  // phonetic digit of one byte
  function automatic logic [DigitW-1:0] letter_digit(input logic [CharW-1:0] c);
    logic [DigitW-1:0] d;
    unique case (c) inside
      "b", "f", "p", "v":                     d = 3'd1;
      "c", "g", "j", "k", "q", "s", "x", "z": d = 3'd2;
      "d", "t":                               d = 3'd3;
      "l":                                    d = 3'd4;
      "m", "n":                               d = 3'd5;
      "r":                                    d = 3'd6;
      default:                                d = 3'd0;
    endcase
    return d;
  endfunction

endpackage

// File: hdl/swmc_if.sv
// input channel: one character word
interface swmc_in_if import swmc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [CharW-1:0] ch;
  logic             last;

  modport source (output valid, kind, ch, last, input ready);
  modport sink   (input valid, kind, ch, last, output ready);
endinterface

// output channel: match count word
interface swmc_out_if import swmc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MatchW-1:0] match_count;

  modport source (output valid, match_count, input ready);
  modport sink   (input valid, match_count, output ready);
endinterface

// File: hdl/soundex_word_match_counter.sv
// channel   dir  payload                 handshake
// in_i      in   kind, ch[7:0], last     valid / ready
// out_o     out  match_count[15:0]       valid / ready
//
// one character word a cycle is taken and processed, sustained while the queue has room and the back is not stalled
// the front classifies each byte in the same cycle and writes it to a four-entry queue
// the back updates the key or word code and the match count one entry a cycle unless it stalls
// the count appears in the output register the cycle after the final sentence byte leaves the queue
// reset clears the key, the count and the queue; the back stalls only on a
// sentence end while the output register is still held, and the queue absorbs up to three more bytes
module soundex_word_match_counter import swmc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  swmc_in_if.sink    in_i,
  swmc_out_if.source out_o
);

  logic        push_valid, push_ready;
  logic        pop_valid, pop_ready;
  swmc_entry_t push_entry, pop_entry;

  // byte classification
  swmc_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry),
    .push_ready_i (push_ready)
  );

  // decoupling queue
  swmc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_entry_o  (pop_entry),
    .pop_ready_i  (pop_ready)
  );

  // code building and counting
  swmc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_entry_i (pop_entry),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule

// File: hdl/swmc_front.sv
module swmc_front import swmc_pkg::*; (
  swmc_in_if.sink     in_i,
  output logic        push_valid_o,
  output swmc_entry_t push_entry_o,
  input  logic        push_ready_i
);

  // classify the byte: delimiter flag and phonetic digit
  always_comb begin
    push_entry_o.kind  = in_i.kind;
    push_entry_o.ch    = in_i.ch;
    push_entry_o.digit = letter_digit(in_i.ch);
    push_entry_o.delim = (in_i.ch == ChDot) || (in_i.ch == ChComma) || (in_i.ch == ChSpace);
    push_entry_o.last  = in_i.last;
  end

  // handshake straight into the queue
  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;

endmodule

// File: hdl/swmc_fifo.sv
`include "assert_macros.svh"

module swmc_fifo import swmc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_valid_i,
  input  swmc_entry_t push_entry_i,
  output logic        push_ready_o,
  output logic        pop_valid_o,
  output swmc_entry_t pop_entry_o,
  input  logic        pop_ready_i
);

  localparam logic [FifoAw:0] CntFull = (FifoAw + 1)'(FifoDepth);

  swmc_entry_t       mem_q [FifoDepth];
  logic [FifoAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoAw:0]   count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != CntFull);
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  // fill level
  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  `SWMC_ASSERT(a_fifo_bound, count_q <= CntFull)
  `SWMC_ASSERT_NEXT(a_fifo_fill, push && !pop, count_q == $past(count_q) + 1'b1)
  `SWMC_ASSERT_NEXT(a_fifo_drain, pop && !push, count_q == $past(count_q) - 1'b1)

endmodule

// File: hdl/swmc_back.sv
`include "assert_macros.svh"

module swmc_back import swmc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pop_valid_i,
  input  swmc_entry_t pop_entry_i,
  output logic        pop_ready_o,
  swmc_out_if.source  out_o
);

  typedef struct packed {
    logic [CodeW-1:0]  digits;
    logic [DwW-1:0]    dw;
    logic [DigitW-1:0] prev;
  } code_t;

  localparam logic [CountW-1:0] CntMax = {CountW{1'b1}};

  // add one non-initial digit to a code being built
  function automatic code_t code_step(input code_t cur, input logic [DigitW-1:0] dig);
    code_t nxt;
    nxt = cur;
    if ((cur.dw != DwW'(NumDigits)) && (dig != cur.prev)) begin
      if (dig != '0) begin
        nxt.digits[DigitW*cur.dw +: DigitW] = dig;
        nxt.dw = cur.dw + 1'b1;
      end
      nxt.prev = dig;
    end
    return nxt;
  endfunction

  logic [CharW-1:0]  key_init_q, key_init_d;
  logic [CodeW-1:0]  key_dig_q, key_dig_d;
  logic [CharW-1:0]  word_init_q, word_init_d;
  logic [CodeW-1:0]  word_dig_q, word_dig_d;
  logic [DwW-1:0]    dw_q, dw_d;
  logic [DigitW-1:0] prev_q, prev_d;
  logic              inside_q, inside_d;
  logic              key_open_q, key_open_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic [MatchW-1:0] out_count_q, out_count_d;

  logic              is_result, pop, close_word, inside_mid;
  logic [CountW-1:0] cnt_mid;
  code_t             step;

  // result words wait only when the output register is still full
  assign is_result   = (pop_entry_i.kind == KindText) && pop_entry_i.last;
  assign pop_ready_o = !is_result || !out_valid_q || out_o.ready;
  assign pop         = pop_valid_i && pop_ready_o;

  // code building and word comparison
  always_comb begin
    key_init_d  = key_init_q;
    key_dig_d   = key_dig_q;
    word_init_d = word_init_q;
    word_dig_d  = word_dig_q;
    dw_d        = dw_q;
    prev_d      = prev_q;
    inside_d    = inside_q;
    key_open_d  = key_open_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_count_d = out_count_q;
    inside_mid  = inside_q;
    cnt_mid     = cnt_q;
    close_word  = 1'b0;
    step        = '0;

    if (pop) begin
      if (pop_entry_i.kind == KindKey) begin
        if (!key_open_q) begin
          // new key: restart code and count
          key_init_d = pop_entry_i.ch;
          key_dig_d  = '0;
          dw_d       = '0;
          prev_d     = '0;
          key_open_d = 1'b1;
          inside_d   = 1'b0;
          cnt_d      = '0;
        end else begin
          step      = code_step('{key_dig_q, dw_q, prev_q}, pop_entry_i.digit);
          key_dig_d = step.digits;
          dw_d      = step.dw;
          prev_d    = step.prev;
        end
        if (pop_entry_i.last) begin
          key_open_d = 1'b0;
        end
      end else begin
        key_open_d = 1'b0;
        // open or extend the current word
        if (!pop_entry_i.delim) begin
          if (!inside_q) begin
            word_init_d = pop_entry_i.ch;
            word_dig_d  = '0;
            dw_d        = '0;
            prev_d      = '0;
            inside_mid  = 1'b1;
          end else begin
            step       = code_step('{word_dig_q, dw_q, prev_q}, pop_entry_i.digit);
            word_dig_d = step.digits;
            dw_d       = step.dw;
            prev_d     = step.prev;
          end
        end
        // close on delimiter or sentence end and compare with the key
        close_word = pop_entry_i.delim || pop_entry_i.last;
        if (close_word && inside_mid && (word_init_d == key_init_q) &&
            (word_dig_d == key_dig_q) && (cnt_q != CntMax)) begin
          cnt_mid = cnt_q + 1'b1;
        end
        inside_d = inside_mid && !close_word;
        if (pop_entry_i.last) begin
          out_valid_d = 1'b1;
          out_count_d = MatchW'(cnt_mid);
          cnt_d       = '0;
        end else begin
          cnt_d = cnt_mid;
        end
      end
    end
  end

  // state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_init_q  <= '0;
      key_dig_q   <= '0;
      word_init_q <= '0;
      word_dig_q  <= '0;
      dw_q        <= '0;
      prev_q      <= '0;
      inside_q    <= 1'b0;
      key_open_q  <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      key_init_q  <= key_init_d;
      key_dig_q   <= key_dig_d;
      word_init_q <= word_init_d;
      word_dig_q  <= word_dig_d;
      dw_q        <= dw_d;
      prev_q      <= prev_d;
      inside_q    <= inside_d;
      key_open_q  <= key_open_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_count_q <= out_count_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.match_count = out_count_q;

  `SWMC_ASSERT(a_key_word_excl, !(key_open_q && inside_q))
  `SWMC_ASSERT_NEXT(a_result_loaded, pop && is_result, out_valid_q)
  `SWMC_ASSERT_NEXT(a_count_cleared, pop && is_result, cnt_q == '0)

endmodule

// File: dv/tb_soundex_word_match_counter.sv
`timescale 1ns / 1ps

module tb_soundex_word_match_counter;
  import swmc_pkg::*;

  localparam time         HalfPeriod  = 5ns;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned RandomChars = 1150;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned BurstWords  = 40;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  swmc_in_if  in_ch ();
  swmc_out_if out_ch ();

  soundex_word_match_counter u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // predictor state: code of the key and of the word being built
  logic [CharW-1:0]  key_lead;
  logic [CodeW-1:0]  key_code;
  logic [CharW-1:0]  word_lead;
  logic [CodeW-1:0]  word_code;
  logic [DwW-1:0]    n_digits;
  logic [DigitW-1:0] prev_digit;
  bit                word_open;
  logic [CountW-1:0] match_total;
  bit                key_in_progress;

  logic [MatchW-1:0] expected_counts[$];

  int unsigned cycles         = 0;
  int unsigned error_count    = 0;
  int unsigned chars_sent     = 0;
  int unsigned counts_checked = 0;
  int unsigned burst_left     = 0;
  bit          steady_feed    = 1'b0;
  int unsigned stall_tick     = 0;
  int unsigned stall_mode     = 0;

  // phonetic digit of one byte
  function automatic logic [DigitW-1:0] phonetic_digit(logic [CharW-1:0] c);
    case (c)
      "b", "f", "p", "v":                     return 3'd1;
      "c", "g", "j", "k", "q", "s", "x", "z": return 3'd2;
      "d", "t":                               return 3'd3;
      "l":                                    return 3'd4;
      "m", "n":                               return 3'd5;
      "r":                                    return 3'd6;
      default:                                return 3'd0;
    endcase
  endfunction

  // add one byte after the initial to a code; zero ends a run but is not written
  function automatic logic [CodeW-1:0] extend_code(logic [CodeW-1:0] code, logic [CharW-1:0] c);
    logic [DigitW-1:0] d;
    logic [CodeW-1:0]  next_code;
    d = phonetic_digit(c);
    next_code = code;
    if (n_digits < NumDigits && d != prev_digit) begin
      if (d != 3'd0) begin
        next_code = code | (CodeW'(d) << (DigitW * n_digits));
        n_digits++;
      end
      prev_digit = d;
    end
    return next_code;
  endfunction

  // compare an open word with the key, count saturates
  function automatic void score_word();
    if (word_open && word_lead == key_lead && word_code == key_code &&
        match_total != {CountW{1'b1}})
      match_total++;
    word_open = 1'b0;
  endfunction

  function automatic void reset_tracker();
    key_lead        = '0;
    key_code        = '0;
    word_lead       = '0;
    word_code       = '0;
    n_digits        = '0;
    prev_digit      = '0;
    word_open       = 1'b0;
    match_total     = '0;
    key_in_progress = 1'b0;
  endfunction

  // expected effect of one accepted word
  function automatic void track_char(input logic kind, input logic [CharW-1:0] ch,
                                     input logic last, output bit emits,
                                     output logic [MatchW-1:0] count);
    emits = 1'b0;
    count = '0;
    if (kind == KindKey) begin
      if (!key_in_progress) begin
        key_lead        = ch;
        key_code        = '0;
        n_digits        = '0;
        prev_digit      = '0;
        key_in_progress = 1'b1;
        word_open       = 1'b0;
        match_total     = '0;
      end else begin
        key_code = extend_code(key_code, ch);
      end
      if (last)
        key_in_progress = 1'b0;
      return;
    end
    key_in_progress = 1'b0;
    if (ch == ChDot || ch == ChComma || ch == ChSpace) begin
      score_word();
    end else if (!word_open) begin
      word_lead  = ch;
      word_code  = '0;
      n_digits   = '0;
      prev_digit = '0;
      word_open  = 1'b1;
    end else begin
      word_code = extend_code(word_code, ch);
    end
    if (last) begin
      score_word();
      emits       = 1'b1;
      count       = MatchW'(match_total);
      match_total = '0;
    end
  endfunction

  // send one word, in random bursts unless a steady feed is asked for
  task automatic send_char(input logic kind, input logic [CharW-1:0] ch, input logic last);
    int unsigned       gap;
    bit                emits;
    logic [MatchW-1:0] count;
    if (!steady_feed && burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    if (burst_left != 0)
      burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.ch    <= ch;
    in_ch.last  <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    track_char(kind, ch, last, emits, count);
    if (emits)
      expected_counts.push_back(count);
    chars_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_string(input logic kind, input string s, input bit mark_last);
    for (int i = 0; i < s.len(); i++)
      send_char(kind, s[i], mark_last && i == s.len() - 1);
  endtask

  task automatic send_bytes(input logic kind, input logic [CharW-1:0] bytes[$],
                            input bit mark_last);
    foreach (bytes[i])
      send_char(kind, bytes[i], mark_last && i == bytes.size() - 1);
  endtask

  // mostly lower-case letters, now and then any byte
  function automatic logic [CharW-1:0] pick_letter();
    if ($urandom_range(0, 4) == 0)
      return CharW'($urandom_range(0, 255));
    return CharW'($urandom_range(8'h61, 8'h7a));
  endfunction

  function automatic logic [CharW-1:0] pick_delimiter();
    case ($urandom_range(0, 2))
      0:       return ChDot;
      1:       return ChComma;
      default: return ChSpace;
    endcase
  endfunction

  // no key given yet: words of a zero byte match the cleared key
  task automatic test_no_key();
    send_char(KindText, 8'h00, 1'b0);
    send_char(KindText, ChSpace, 1'b0);
    send_char(KindText, 8'h00, 1'b1);
  endtask

  // adjacent delimiters, single-letter word, unpunctuated end, delimiter as last
  task automatic test_delimiters();
    send_string(KindKey, "rr", 1'b1);
    send_string(KindText, "rr,, r. rr", 1'b1);
    send_string(KindText, "rr ", 1'b1);
  endtask

  // raw initials, upper case breaking a run, every digit group, three-digit limit
  task automatic test_coding();
    send_char(KindKey, 8'hff, 1'b0);
    send_string(KindKey, "bBp", 1'b1);
    send_char(KindText, 8'hff, 1'b0);
    send_string(KindText, "vAf.", 1'b1);
    send_string(KindKey, "abcdlmnr", 1'b1);
    send_string(KindText, "abcdz aBcd", 1'b1);
  endtask

  // new key clears a sentence in progress; a sentence closes an open key
  task automatic test_key_changes();
    send_string(KindText, "ab ", 1'b0);
    send_string(KindKey, "ab", 1'b1);
    send_string(KindText, "ab", 1'b1);
    send_string(KindKey, "mn", 1'b0);
    send_string(KindText, "mn,m", 1'b1);
  endtask

  // a long run of matching words fed with no gaps
  task automatic test_back_to_back();
    steady_feed = 1'b1;
    send_string(KindKey, "a", 1'b1);
    for (int i = 0; i < BurstWords; i++) begin
      send_char(KindText, "a", 1'b0);
      send_char(KindText, ChSpace, 1'b0);
    end
    send_char(KindText, "a", 1'b1);
    steady_feed = 1'b0;
  endtask

  // keys and sentences built around them, with noise and broken sentences
  task automatic test_random_sentences(input int unsigned n_chars);
    logic [CharW-1:0] key_text[$];
    logic [CharW-1:0] line[$];
    int unsigned      stop_at;
    int unsigned      n_words;
    int unsigned      pick;
    bit               need_key;
    bit               mark_last;
    stop_at  = chars_sent + n_chars;
    need_key = 1'b1;
    while (chars_sent < stop_at) begin
      if (need_key || $urandom_range(0, 5) == 0) begin
        key_text.delete();
        repeat ($urandom_range(1, 6)) key_text.push_back(pick_letter());
        send_bytes(KindKey, key_text, $urandom_range(0, 19) != 0);
        need_key = 1'b0;
      end
      line.delete();
      n_words = $urandom_range(1, 8);
      for (int w = 0; w < n_words; w++) begin
        repeat ($urandom_range(w == 0 ? 0 : 1, 2)) line.push_back(pick_delimiter());
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          foreach (key_text[i]) line.push_back(key_text[i]);
        end else if (pick < 6) begin
          foreach (key_text[i])
            line.push_back((i > 0 && $urandom_range(0, 2) == 0) ? pick_letter() : key_text[i]);
        end else if (pick < 9) begin
          repeat ($urandom_range(1, 7)) line.push_back(pick_letter());
        end else begin
          repeat ($urandom_range(1, 4)) line.push_back(CharW'($urandom_range(0, 255)));
        end
      end
      if ($urandom_range(0, 1) == 1)
        line.push_back(pick_delimiter());
      mark_last = $urandom_range(0, 19) != 0;
      send_bytes(KindText, line, mark_last);
      need_key = !mark_last;
    end
  endtask

  // receiver: switch between stall patterns
  always @(negedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 64 == 0)
      stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= $urandom_range(0, 1);
      2:       out_ch.ready <= (stall_tick % 8 == 0);
      default: out_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // check each accepted count against the oldest expectation
  always @(posedge clk_i) begin : check_counts
    logic [MatchW-1:0] want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_counts.size() == 0) begin
        $error("match_count: expected none, actual %0d", out_ch.match_count);
        error_count++;
      end else begin
        want = expected_counts.pop_front();
        if (out_ch.match_count !== want) begin
          $error("match_count: expected %0d, actual %0d", want, out_ch.match_count);
          error_count++;
        end
        counts_checked++;
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("soundex_word_match_counter test failed");
      $finish;
    end
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.kind   = KindKey;
    in_ch.ch     = '0;
    in_ch.last   = 1'b0;
    out_ch.ready = 1'b0;
    reset_tracker();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_no_key();
    test_delimiters();
    test_coding();
    test_key_changes();
    test_back_to_back();
    test_random_sentences(RandomChars);

    // let the last counts come out
    in_ch.valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d characters (keys, sentences, a gapless run, random text)", chars_sent);
    $display("checked %0d match counts in %0d cycles", counts_checked, cycles);
    if (error_count == 0 && expected_counts.size() == 0) begin
      $display("soundex_word_match_counter test passed");
    end else begin
      $display("soundex_word_match_counter test failed");
    end
    $finish;
  end

endmodule
